// ===== rtl/bsu_pkg.sv =====
// Shared constants, types and the Pascal triangle table for the Banker's sequence unranker.
package bsu_pkg;

  localparam int MAX_BITS = 16;
  localparam int RANK_W   = 16;
  localparam int WORD_W   = 16;
  localparam int CFG_W    = 5;
  localparam logic [CFG_W-1:0] BIT_LENGTH_RST = CFG_W'(8);

  // n, c, k and pos all range over 0..MAX_BITS
  localparam int NW    = $clog2(MAX_BITS + 1);
  // C(n,k) < 2^n for n >= 1
  localparam int CW    = MAX_BITS;
  localparam int CMPW  = (MAX_BITS > RANK_W) ? MAX_BITS : RANK_W;
  // triangle stored row by row, k <= n only
  localparam int TRI_N = (MAX_BITS + 1) * (MAX_BITS + 2) / 2;
  localparam int TIW   = $clog2(TRI_N);

  typedef logic [CW-1:0]  tri_tab_t  [TRI_N];
  typedef logic [TIW-1:0] tri_base_t [MAX_BITS + 1];

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLASS,
    ST_BITS,
    ST_DONE
  } state_t;

  // request to the shared binomial subtract-compare unit
  typedef struct packed {
    logic [NW-1:0]     row;
    logic [NW-1:0]     col;
    logic [RANK_W-1:0] rem;
  } step_req_t;

  typedef struct packed {
    logic              below;  // rem < C(row,col)
    logic [RANK_W-1:0] diff;   // rem - C(row,col), meaningful when !below
  } step_rsp_t;

  function automatic tri_tab_t build_tri();
    tri_tab_t t;
    int       base;
    for (int i = 0; i < TRI_N; i++) t[i] = '0;
    for (int n = 0; n <= MAX_BITS; n++) begin
      base = n * (n + 1) / 2;
      for (int k = 0; k <= n; k++) begin
        if (k == 0 || k == n) begin
          t[base + k] = CW'(1);
        end else begin
          t[base + k] = t[base - n + k - 1] + t[base - n + k];
        end
      end
    end
    return t;
  endfunction

  function automatic tri_base_t build_base();
    tri_base_t b;
    for (int n = 0; n <= MAX_BITS; n++) b[n] = TIW'(n * (n + 1) / 2);
    return b;
  endfunction

  localparam tri_tab_t  PASCAL   = build_tri();
  localparam tri_base_t ROW_BASE = build_base();

endpackage

// ===== rtl/bsu_binom_unit.sv =====
// Shared step unit: looks up C(row,col) and subtract-compares it against the remainder.
module bsu_binom_unit (
  input  bsu_pkg::step_req_t req,
  output bsu_pkg::step_rsp_t rsp
);

  logic [bsu_pkg::TIW-1:0]  idx;
  logic [bsu_pkg::CW-1:0]   coef;
  logic [bsu_pkg::CMPW-1:0] rem_x;
  logic [bsu_pkg::CMPW-1:0] coef_x;
  logic [bsu_pkg::CMPW-1:0] diff_x;

  assign idx = bsu_pkg::ROW_BASE[req.row] + bsu_pkg::TIW'(req.col);

  // C(n,k) = 0 for k > n
  assign coef   = (req.col > req.row) ? '0 : bsu_pkg::PASCAL[idx];
  assign rem_x  = bsu_pkg::CMPW'(req.rem);
  assign coef_x = bsu_pkg::CMPW'(coef);
  assign diff_x = rem_x - coef_x;

  assign rsp.below = rem_x < coef_x;
  assign rsp.diff  = diff_x[bsu_pkg::RANK_W-1:0];

endmodule

// ===== rtl/bankers_sequence_unrank_core.sv =====
// Banker's sequence unranker: turns a rank into the n-bit word at that position.
// One rank at a time. After the input transfer the sequencer runs one binomial
// subtract-compare per cycle through a single shared unit: first c+1 steps to find
// the popcount class c, then up to n steps deciding bits from bit n-1 down (stopping
// once all ones are placed) and a closing step that leaves that phase, then the
// hand-off of the result to the output register. out_valid rises and in_ready returns
// in the same cycle, at the hand-off; an out-of-range rank (rank >= 2^n) skips both
// phases and goes straight to the hand-off with word 0 and out_of_range set. The
// hand-off waits while the output register still holds an undrained result. in_ready
// is high only while the sequencer is idle; a finished result waits in the output
// register so the next rank can be taken before it is drained. cfg_ready is always
// high; bit_length is sampled at each input transfer, 0 acts as 1 and values above
// 16 act as 16.
module bankers_sequence_unrank_core (
  input  logic                         clk,
  input  logic                         rst_n,

  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bsu_pkg::CFG_W-1:0]    cfg_bit_length,

  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [bsu_pkg::RANK_W-1:0]   in_rank,

  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bsu_pkg::WORD_W-1:0]   out_word,
  output logic                         out_out_of_range
);

  bsu_pkg::state_t state_r, state_nxt;

  logic [bsu_pkg::CFG_W-1:0]    bit_length_r;
  logic [bsu_pkg::NW-1:0]       n_eff;
  logic [bsu_pkg::NW-1:0]       n_r, n_nxt;
  logic [bsu_pkg::NW-1:0]       c_r, c_nxt;
  logic [bsu_pkg::NW-1:0]       pos_r, pos_nxt;
  logic [bsu_pkg::RANK_W-1:0]   rem_r, rem_nxt;
  logic [bsu_pkg::MAX_BITS-1:0] word_r, word_nxt;
  logic                         oor_r, oor_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [bsu_pkg::WORD_W-1:0]   out_word_r, out_word_nxt;
  logic                         out_oor_r, out_oor_nxt;

  logic                         in_xfer;
  logic                         rank_oor;
  logic                         out_free;
  logic                         class_go;
  logic                         bits_go;
  logic [bsu_pkg::NW-1:0]       pos_m1;

  bsu_pkg::step_req_t step_req;
  bsu_pkg::step_rsp_t step_rsp;

  bsu_binom_unit u_binom (
    .req (step_req),
    .rsp (step_rsp)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == bsu_pkg::ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_word         = out_word_r;
  assign out_out_of_range = out_oor_r;

  always_comb begin
    if (bit_length_r == '0) begin
      n_eff = bsu_pkg::NW'(1);
    end else if (int'(bit_length_r) > bsu_pkg::MAX_BITS) begin
      n_eff = bsu_pkg::NW'(bsu_pkg::MAX_BITS);
    end else begin
      n_eff = bsu_pkg::NW'(bit_length_r);
    end
  end

  assign rank_oor = ((bsu_pkg::CMPW'(in_rank) >> n_eff) != '0);

  // c doubles as k (ones still to place) during the bit phase
  assign class_go = (c_r <= n_r) && !step_rsp.below;
  assign bits_go  = (pos_r != '0) && (c_r != '0);
  assign pos_m1   = pos_r - 1'b1;

  always_comb begin
    step_req.rem = rem_r;
    if (state_r == bsu_pkg::ST_BITS) begin
      step_req.row = pos_m1;
      step_req.col = c_r - 1'b1;
    end else begin
      step_req.row = n_r;
      step_req.col = c_r;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bsu_pkg::ST_IDLE: begin
        if (in_xfer) state_nxt = rank_oor ? bsu_pkg::ST_DONE : bsu_pkg::ST_CLASS;
      end
      bsu_pkg::ST_CLASS: begin
        if (!class_go) state_nxt = bsu_pkg::ST_BITS;
      end
      bsu_pkg::ST_BITS: begin
        if (!bits_go) state_nxt = bsu_pkg::ST_DONE;
      end
      bsu_pkg::ST_DONE: begin
        if (out_free) state_nxt = bsu_pkg::ST_IDLE;
      end
      default: state_nxt = bsu_pkg::ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    n_nxt         = n_r;
    c_nxt         = c_r;
    pos_nxt       = pos_r;
    rem_nxt       = rem_r;
    word_nxt      = word_r;
    oor_nxt       = oor_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_word_nxt  = out_word_r;
    out_oor_nxt   = out_oor_r;
    unique case (state_r)
      bsu_pkg::ST_IDLE: begin
        if (in_xfer) begin
          n_nxt    = n_eff;
          c_nxt    = '0;
          pos_nxt  = n_eff;
          rem_nxt  = in_rank;
          word_nxt = '0;
          oor_nxt  = rank_oor;
        end
      end
      bsu_pkg::ST_CLASS: begin
        if (class_go) begin
          rem_nxt = step_rsp.diff;
          c_nxt   = c_r + 1'b1;
        end
      end
      bsu_pkg::ST_BITS: begin
        if (bits_go) begin
          pos_nxt = pos_m1;
          if (step_rsp.below) begin
            word_nxt = word_r | (bsu_pkg::MAX_BITS'(1) << pos_m1);
            c_nxt    = c_r - 1'b1;
          end else begin
            rem_nxt = step_rsp.diff;
          end
        end
      end
      bsu_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = bsu_pkg::WORD_W'(word_r);
          out_oor_nxt   = oor_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bsu_pkg::ST_IDLE;
      bit_length_r <= bsu_pkg::BIT_LENGTH_RST;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) bit_length_r <= cfg_bit_length;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    c_r        <= c_nxt;
    pos_r      <= pos_nxt;
    rem_r      <= rem_nxt;
    word_r     <= word_nxt;
    oor_r      <= oor_nxt;
    out_word_r <= out_word_nxt;
    out_oor_r  <= out_oor_nxt;
  end

`ifndef NO_ASSERTIONS
  a_oor_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_oor_r |-> out_word_r == '0)
    else $error("out-of-range result with nonzero word");

  a_class_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bsu_pkg::ST_CLASS |-> c_r <= n_r)
    else $error("popcount class ran past n");

  a_ones_fit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bsu_pkg::ST_BITS |-> c_r <= pos_r)
    else $error("more ones left than bit positions");

  a_oor_shortcut: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && rank_oor |=> state_r == bsu_pkg::ST_DONE && oor_r)
    else $error("out-of-range rank did not go straight to done");
`endif

endmodule

// ===== bench/bankers_sequence_unrank_core_tb.sv =====
// Self-checking testbench for the Banker's sequence unranker core.
module bankers_sequence_unrank_core_tb;

  localparam int RANK_W = bsu_pkg::RANK_W;
  localparam int WORD_W = bsu_pkg::WORD_W;
  localparam int CFG_W  = bsu_pkg::CFG_W;
  localparam int N_MAX  = bsu_pkg::MAX_BITS;
  localparam int SETTLE = 40;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              oor;
  } unrank_t;

  // typed = 1: expected result given in the row, else predicted
  typedef struct packed {
    logic [CFG_W-1:0]  bits;
    logic [RANK_W-1:0] rank;
    logic              typed;
    logic [WORD_W-1:0] word;
    logic              oor;
  } dir_row_t;

  localparam int N_DIR = 24;
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{5'd8,  16'd0,     1'b1, 16'h0000, 1'b0},
    '{5'd8,  16'd1,     1'b1, 16'h0080, 1'b0},
    '{5'd8,  16'd8,     1'b1, 16'h0001, 1'b0},
    '{5'd8,  16'd9,     1'b1, 16'h00C0, 1'b0},
    '{5'd8,  16'd255,   1'b1, 16'h00FF, 1'b0},
    '{5'd8,  16'd256,   1'b1, 16'h0000, 1'b1},
    '{5'd8,  16'd65535, 1'b1, 16'h0000, 1'b1},
    '{5'd8,  16'd100,   1'b0, 16'h0000, 1'b0},
    '{5'd16, 16'd0,     1'b1, 16'h0000, 1'b0},
    '{5'd16, 16'd1,     1'b1, 16'h8000, 1'b0},
    '{5'd16, 16'd65535, 1'b1, 16'hFFFF, 1'b0},
    '{5'd16, 16'd32768, 1'b0, 16'h0000, 1'b0},
    '{5'd16, 16'd12345, 1'b0, 16'h0000, 1'b0},
    '{5'd1,  16'd0,     1'b1, 16'h0000, 1'b0},
    '{5'd1,  16'd1,     1'b1, 16'h0001, 1'b0},
    '{5'd1,  16'd2,     1'b1, 16'h0000, 1'b1},
    '{5'd0,  16'd1,     1'b1, 16'h0001, 1'b0},
    '{5'd0,  16'd2,     1'b1, 16'h0000, 1'b1},
    '{5'd31, 16'd65535, 1'b1, 16'hFFFF, 1'b0},
    '{5'd31, 16'd17,    1'b1, 16'hC000, 1'b0},
    '{5'd17, 16'd1,     1'b1, 16'h8000, 1'b0},
    '{5'd5,  16'd31,    1'b1, 16'h001F, 1'b0},
    '{5'd5,  16'd32,    1'b1, 16'h0000, 1'b1},
    '{5'd5,  16'd6,     1'b1, 16'h0018, 1'b0}
  };

  localparam int N_PHASES = 12;
  localparam int PHASE_ITEMS = 120;
  localparam logic [CFG_W-1:0] PHASE_FIXED [7] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd3, 5'd17, 5'd8};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_W-1:0] cfg_bit_length = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [RANK_W-1:0] in_rank = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [WORD_W-1:0] out_word;
  logic out_out_of_range;

  unrank_t pending_words[$];
  logic [CFG_W-1:0] model_bits = bsu_pkg::BIT_LENGTH_RST;
  int errors = 0;
  int rx_left = 0;
  int rx_mode = 0;

  always #5 clk = ~clk;

  bankers_sequence_unrank_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_bit_length   (cfg_bit_length),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rank          (in_rank),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_word         (out_word),
    .out_out_of_range (out_out_of_range)
  );

  function automatic longint binom_count(int a, int b);
    longint res;
    res = 1;
    if (b > a) return 0;
    for (int j = 0; j < b; j++) res = res * (a - j) / (j + 1);
    return res;
  endfunction

  function automatic int eff_bits(logic [CFG_W-1:0] bits);
    if (bits == 0) return 1;
    if (bits > N_MAX) return N_MAX;
    return int'(bits);
  endfunction

  function automatic unrank_t unrank_word(logic [RANK_W-1:0] rank, logic [CFG_W-1:0] bits);
    unrank_t res;
    int      n;
    int      c;
    int      k;
    longint  rem;
    longint  with_one;
    n = eff_bits(bits);
    res = '0;
    rem = longint'(rank);
    if (rem >= (longint'(1) << n)) begin
      res.oor = 1'b1;
      return res;
    end
    // popcount class first, then the index inside it
    c = 0;
    while (c <= n && rem >= binom_count(n, c)) begin
      rem -= binom_count(n, c);
      c++;
    end
    k = c;
    for (int pos = n; pos > 0 && k > 0; pos--) begin
      with_one = binom_count(pos - 1, k - 1);
      if (rem < with_one) begin
        res.word[pos-1] = 1'b1;
        k--;
      end else begin
        rem -= with_one;
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= 30) $display("ERROR at %0t: %s", $time, msg);
  endtask

  // valid stays high after the transfer; the caller lowers it
  task automatic send_rank(logic [RANK_W-1:0] rank, logic typed, unrank_t typed_res);
    @(negedge clk);
    in_valid <= 1'b1;
    in_rank  <= rank;
    do @(posedge clk); while (!in_ready);
    pending_words.push_back(typed ? typed_res : unrank_word(rank, model_bits));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_bit_length(logic [CFG_W-1:0] bits);
    wait_drained();
    @(negedge clk);
    cfg_valid      <= 1'b1;
    cfg_bit_length <= bits;
    do @(posedge clk); while (!cfg_ready);
    model_bits = bits;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [RANK_W-1:0] pick_rank(int n);
    int sel;
    longint span;
    sel = $urandom_range(0, 99);
    span = (longint'(1) << n);
    if (sel < 70) return RANK_W'($urandom_range(0, int'(span - 1)));
    if (sel < 80) return (n < N_MAX && sel < 75) ? RANK_W'(span) : RANK_W'(span - 1);
    if (sel < 85) return '0;
    return RANK_W'($urandom);
  endfunction

  // receiver: stall mode changes every so often
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(20, 200);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      0: begin
        out_ready <= 1'b1;
      end
      1: begin
        out_ready <= 1'($urandom_range(0, 1));
      end
      2: begin
        out_ready <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        out_ready <= (rx_left % 16 == 0);
      end
    endcase
  end

  always @(posedge clk) begin
    unrank_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        report_mismatch($sformatf("unexpected result word=%h oor=%b", out_word,
                                  out_out_of_range));
      end else begin
        exp_res = pending_words.pop_front();
        if (out_word !== exp_res.word)
          report_mismatch($sformatf("word %h, expected %h", out_word, exp_res.word));
        if (out_out_of_range !== exp_res.oor)
          report_mismatch($sformatf("out_of_range %b, expected %b", out_out_of_range,
                                    exp_res.oor));
      end
    end
  end

  initial begin
    int n;
    int left;
    int burst;
    int gap;
    logic [CFG_W-1:0] bits;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIR; i++) begin
      if (DIR_ROWS[i].bits != model_bits) set_bit_length(DIR_ROWS[i].bits);
      send_rank(DIR_ROWS[i].rank, DIR_ROWS[i].typed, {DIR_ROWS[i].word, DIR_ROWS[i].oor});
    end

    for (int p = 0; p < N_PHASES; p++) begin
      bits = (p < 7) ? PHASE_FIXED[p] : CFG_W'($urandom_range(0, 31));
      set_bit_length(bits);
      n = eff_bits(bits);
      left = PHASE_ITEMS;
      while (left > 0) begin
        burst = $urandom_range(1, 12);
        for (int b = 0; b < burst && left > 0; b++) begin
          send_rank(pick_rank(n), 1'b0, '0);
          left--;
        end
        if ($urandom_range(0, 39) == 0) begin
          wait_drained();
        end else begin
          gap = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(0, 4);
          if (gap > 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
          end
        end
      end
    end

    wait_drained();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("timeout, %0d results outstanding", pending_words.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
